// File: rtl/rightmost_free_slot_allocator_core_defines.svh
// Assertion macros shared by the checker of the slot allocator.
`ifndef RIGHTMOST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define RIGHTMOST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RFSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfsa check failed");

// Next-cycle implication, disabled while reset is held.
`define RFSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfsa check failed");

`endif

// File: rtl/rfsa_pkg.sv
`timescale 1ns / 1ps

package rfsa_pkg;

  localparam int FIELD_W      = 11;
  localparam int CMD_W        = 2;
  localparam int SLOTS_DEF    = 1024;
  localparam int ACTIVE_RESET = 1024;

  // Width of one row of the taken bitmap and of one summary word.
  localparam int ROW_W  = 32;
  localparam int ROW_AW = 5;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLACE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Index of the highest set bit; zero when none is set.
  function automatic logic [ROW_AW-1:0] high_bit(input logic [ROW_W-1:0] v);
    logic [ROW_AW-1:0] h;
    h = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) h = ROW_AW'(i);
    end
    return h;
  endfunction

  // Mask with every bit at or below position k set.
  function automatic logic [ROW_W-1:0] le_mask(input logic [ROW_AW-1:0] k);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i <= int'(k));
    end
    return m;
  endfunction

endpackage

// File: rtl/rightmost_free_slot_allocator_core.sv
`timescale 1ns / 1ps

// Slot allocator: hands out the highest-numbered free slot at or below a limit,
// stores a value there, and serves reads and clear-all. Taken marks live in a
// bitmap memory of 32-slot rows, backed by a summary memory with one "row
// full" bit per row; values live in a third memory. One item is worked at a
// time, each step being one synchronous memory read followed by a write. A
// place first reads its limit row; if that row has a free slot it is taken,
// and the row's summary bit is set when the row fills. Otherwise summary
// words, each covering 32 rows, are scanned downward and the chosen row is
// reread. A clear runs a clearing pass over the bitmap rows (ROWS =
// SLOTS/32, rounded up). After reset the same pass runs before the first
// item is taken; configuration writes are accepted throughout.
module rightmost_free_slot_allocator_core #(
  parameter int SLOTS = rfsa_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rfsa_pkg::FIELD_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rfsa_pkg::CMD_W-1:0]   in_cmd,
  input  logic [rfsa_pkg::FIELD_W-1:0] in_limit,
  input  logic [rfsa_pkg::FIELD_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rfsa_pkg::FIELD_W-1:0] out_slot,
  output logic [rfsa_pkg::FIELD_W-1:0] out_read_value
);

  localparam int RW_BITS = rfsa_pkg::ROW_W;
  localparam int RA_BITS = rfsa_pkg::ROW_AW;
  localparam int FW      = rfsa_pkg::FIELD_W;
  localparam int ROWS    = (SLOTS + RW_BITS - 1) / RW_BITS;
  localparam int SROWS   = (ROWS + RW_BITS - 1) / RW_BITS;
  localparam int IW      = $clog2(SLOTS);
  localparam int SW      = $clog2(SLOTS + 1);
  localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SRW     = (SROWS > 1) ? $clog2(SROWS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEAF = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SUMU = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [FW-1:0]      active_r, active_nxt;
  logic [FW-1:0]      value_r, value_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [RA_BITS-1:0] bitlim_r, bitlim_nxt;
  logic [SRW-1:0]     sw_r, sw_nxt;
  logic [RA_BITS-1:0] sumlim_r, sumlim_nxt;
  logic [RW-1:0]      clr_r, clr_nxt;
  logic               clr_ack_r, clr_ack_nxt;
  logic [FW-1:0]      res_slot_r, res_slot_nxt;
  logic [FW-1:0]      res_rd_r, res_rd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FW-1:0]      out_slot_r, out_slot_nxt;
  logic [FW-1:0]      out_read_value_r, out_read_value_nxt;

  // Taken bitmap, row-full summary and stored values.
  logic [RW_BITS-1:0] leaf_mem [ROWS];
  logic [RW_BITS-1:0] sum_mem  [SROWS];
  logic [FW-1:0]      val_mem  [SLOTS];

  logic [RW_BITS-1:0] leaf_q_r, sum_q_r;
  logic [FW-1:0]      val_q_r;

  logic               leaf_we, sum_we, val_we;
  logic [RW-1:0]      leaf_waddr, leaf_raddr;
  logic [SRW-1:0]     sum_waddr, sum_raddr;
  logic [IW-1:0]      val_waddr, val_raddr;
  logic [RW_BITS-1:0] leaf_wdata, sum_wdata;

  logic [SW-1:0]      n_eff;
  logic [SW-1:0]      s_lim;
  logic [31:0]        idx32;
  logic [31:0]        pos32;
  logic [31:0]        t32;
  logic [RW_BITS-1:0] free_v, avail_v, new_row;
  logic [RA_BITS-1:0] hi, ci;

  always_comb begin
    if (32'(active_r) < 32'(SLOTS)) n_eff = SW'(active_r);
    else                             n_eff = SW'(SLOTS);
    if (32'(in_limit) < 32'(n_eff)) s_lim = SW'(in_limit);
    else                             s_lim = n_eff;
    idx32   = 32'(s_lim) - 32'd1;
    free_v  = ~leaf_q_r & rfsa_pkg::le_mask(bitlim_r);
    hi      = rfsa_pkg::high_bit(free_v);
    new_row = leaf_q_r | (RW_BITS'(1) << hi);
    pos32   = 32'(row_r) * 32'(RW_BITS) + 32'(hi);
    avail_v = ~sum_q_r & rfsa_pkg::le_mask(sumlim_r);
    ci      = rfsa_pkg::high_bit(avail_v);
    t32     = 32'(row_r) - 32'd1;
  end

  always_comb begin
    state_nxt          = state_r;
    active_nxt         = active_r;
    value_nxt          = value_r;
    row_nxt            = row_r;
    bitlim_nxt         = bitlim_r;
    sw_nxt             = sw_r;
    sumlim_nxt         = sumlim_r;
    clr_nxt            = clr_r;
    clr_ack_nxt        = clr_ack_r;
    res_slot_nxt       = res_slot_r;
    res_rd_nxt         = res_rd_r;
    out_valid_nxt      = out_valid_r;
    out_slot_nxt       = out_slot_r;
    out_read_value_nxt = out_read_value_r;

    leaf_we    = 1'b0;
    leaf_waddr = row_r;
    leaf_wdata = new_row;
    leaf_raddr = RW'(idx32 >> RA_BITS);
    sum_we     = 1'b0;
    sum_waddr  = SRW'(32'(row_r) >> RA_BITS);
    sum_wdata  = sum_q_r | (RW_BITS'(1) << RA_BITS'(32'(row_r)));
    sum_raddr  = SRW'(32'(row_r) >> RA_BITS);
    val_we     = 1'b0;
    val_waddr  = IW'(pos32);
    val_raddr  = IW'(32'(in_limit) - 32'd1);

    in_ready = (state_r == S_IDLE);

    if (cfg_wr_en) active_nxt = cfg_wr_data;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt    = in_value;
          res_slot_nxt = '0;
          res_rd_nxt   = '0;
          state_nxt    = S_DONE;
          case (in_cmd)
            rfsa_pkg::CMD_CLEAR: begin
              clr_nxt     = '0;
              clr_ack_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            rfsa_pkg::CMD_PLACE: begin
              if (s_lim != '0) begin
                row_nxt    = RW'(idx32 >> RA_BITS);
                bitlim_nxt = RA_BITS'(idx32);
                state_nxt  = S_LEAF;
              end
            end
            rfsa_pkg::CMD_READ: begin
              if (in_limit != '0 && 32'(in_limit) <= 32'(n_eff)) state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_LEAF: begin
        if (free_v != '0) begin
          leaf_we      = 1'b1;
          val_we       = 1'b1;
          res_slot_nxt = FW'(pos32 + 32'd1);
          // Filling the row sets its full bit in the summary word.
          if (&new_row) state_nxt = S_SUMU;
          else          state_nxt = S_DONE;
        end else if (row_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sum_raddr  = SRW'(t32 >> RA_BITS);
          sw_nxt     = SRW'(t32 >> RA_BITS);
          sumlim_nxt = RA_BITS'(t32);
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        if (avail_v != '0) begin
          leaf_raddr = RW'(32'(sw_r) * 32'(RW_BITS) + 32'(ci));
          row_nxt    = RW'(32'(sw_r) * 32'(RW_BITS) + 32'(ci));
          bitlim_nxt = RA_BITS'(RW_BITS - 1);
          state_nxt  = S_LEAF;
        end else if (sw_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sum_raddr  = sw_r - SRW'(1);
          sw_nxt     = sw_r - SRW'(1);
          sumlim_nxt = RA_BITS'(RW_BITS - 1);
        end
      end
      S_SUMU: begin
        sum_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD: begin
        res_rd_nxt = val_q_r;
        state_nxt  = S_DONE;
      end
      S_CLR: begin
        leaf_we    = 1'b1;
        leaf_waddr = clr_r;
        leaf_wdata = '0;
        if (32'(clr_r) < 32'(SROWS)) begin
          sum_we    = 1'b1;
          sum_waddr = SRW'(clr_r);
          sum_wdata = '0;
        end
        if (clr_r == RW'(ROWS - 1)) begin
          clr_ack_nxt = 1'b0;
          state_nxt   = clr_ack_r ? S_DONE : S_IDLE;
        end else begin
          clr_nxt = clr_r + RW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_slot_nxt       = res_slot_r;
          out_read_value_nxt = res_rd_r;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      active_r    <= FW'(rfsa_pkg::ACTIVE_RESET);
      clr_r       <= '0;
      clr_ack_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      clr_r       <= clr_nxt;
      clr_ack_r   <= clr_ack_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r          <= value_nxt;
    row_r            <= row_nxt;
    bitlim_r         <= bitlim_nxt;
    sw_r             <= sw_nxt;
    sumlim_r         <= sumlim_nxt;
    res_slot_r       <= res_slot_nxt;
    res_rd_r         <= res_rd_nxt;
    out_slot_r       <= out_slot_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    leaf_q_r <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_q_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= value_r;
    val_q_r <= val_mem[val_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_read_value = out_read_value_r;

endmodule

// File: rtl/rfsa_checker.sv
`timescale 1ns / 1ps
`include "rightmost_free_slot_allocator_core_defines.svh"

module rfsa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rfsa_pkg::FIELD_W-1:0] out_slot,
  input logic [rfsa_pkg::FIELD_W-1:0] out_read_value
);

  // A result waiting for the consumer keeps its value.
  `RFSA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_slot) && $stable(out_read_value))

  // Only one item is in work at a time.
  `RFSA_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // A result never carries both a slot number and a read value.
  `RFSA_ASSERT_IMP(a_one_field, clk, rst_n, out_valid && out_slot != '0,
                   out_read_value == '0)

endmodule

bind rightmost_free_slot_allocator_core rfsa_checker u_rfsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_slot       (out_slot),
  .out_read_value (out_read_value)
);
